// ----- rtl/lrlf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrlf_pkg
// Shared types, constants and helpers for the LED ring level frame renderer.
// ----------------------------------------------------------------------------
package lrlf_pkg;

	localparam int PIXEL_COUNT = 12;
	localparam int PIX_W       = $clog2(PIXEL_COUNT);
	localparam int LIT_W       = $clog2(PIXEL_COUNT + 1);

	localparam int NOW_W      = 32;
	localparam int STEP_W     = 16;
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = NOW_W / DIV_BITS;

	localparam int CFG_IDX_W = 1;

	localparam int RESET_STEP    = 90;
	localparam int RESET_GLOW    = 18;
	localparam int BASE_MIN      = 10;
	localparam int BASE_SPAN     = 150;
	localparam int SHIMMER_BOOST = 35;
	localparam int DIM_LEVEL     = 4;
	localparam int GREEN_BASE    = 55;
	localparam int GREEN_SPAN    = 20;
	localparam int BLUE_MUL      = 18;
	localparam int MAX_LEVEL     = 255;
	localparam int MOD_W         = $clog2(GREEN_SPAN);

	typedef enum logic [1:0] {
		FUNC_LEVEL = 2'd0,
		FUNC_OFF   = 2'd1,
		FUNC_GLOW  = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHIMMER_STEP = 1'b0,
		REG_GLOW_LEVEL   = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]       func;
		logic [7:0]       energy;
		logic [NOW_W-1:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [3:0] pixel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} pix_t;

	// floor(x / 255), exact for products of two 8-bit values
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = 17'(x) + 17'(x[15:8]) + 17'd1;
		return s[15:8];
	endfunction

endpackage

// ----- rtl/led_ring_level_frame.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_ring_level_frame
// Renders one warm-colored LED ring frame per request, one pixel item a cycle while pix_ready holds.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req): one item asks for a whole frame:
//   mode (level bar, off, glow), energy level and current time in ms.
//   pix channel (pix_valid/pix_ready/pix): PIXEL_COUNT items per frame in
//   pixel order, last_pixel set on the final one.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always ready; write only while no frame is in flight.
// Path: request, stage 1, divider stages, serializer, px1, px2, output reg.
// Throughput: one pixel a cycle from the pixel serializer unless pix_ready
//   stalls it; requests flow back to back through the front pipeline and
//   queue behind the serializer.
// Reset: all pipelines empty, shimmer step = 90 ms, glow level = 18.
// Stall: when pix_ready is low every stage holds; nothing is lost or repeated,
//   and req_ready drops only once all stages in front are full.
// ----------------------------------------------------------------------------
module led_ring_level_frame (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  lrlf_pkg::req_t                  req,
	output logic                            pix_valid,
	input  logic                            pix_ready,
	output lrlf_pkg::pix_t                  pix,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lrlf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lrlf_pkg::STEP_W-1:0]     cfg_data
);
	import lrlf_pkg::*;

	// Stage 1: captured request with the two energy products
	typedef struct packed {
		logic [1:0]        func;
		logic [STEP_W-1:0] step;
		logic [7:0]        glow;
		logic [NOW_W-1:0]  now;
		logic [15:0]       prod_lit;
		logic [15:0]       prod_base;
	} s1_t;

	// Divider stages: partial remainder, remaining dividend bits and
	// quotient mod PIXEL_COUNT, plus frame parameters riding along
	typedef struct packed {
		logic [STEP_W-1:0] rem;
		logic [NOW_W-1:0]  num;
		logic [STEP_W-1:0] step;
		logic [PIX_W-1:0]  pos;
		logic [1:0]        func;
		logic [LIT_W-1:0]  lit;
		logic [7:0]        base;
		logic [7:0]        glow;
	} div_t;

	typedef struct packed {
		logic [1:0]       func;
		logic [LIT_W-1:0] lit;
		logic [7:0]       base;
		logic [7:0]       glow;
		logic [PIX_W-1:0] pos;
	} frame_t;

	typedef struct packed {
		logic [PIX_W-1:0] idx;
		logic [MOD_W-1:0] mod;
		logic [7:0]       level;
		logic             last;
	} px1_t;

	typedef struct packed {
		logic [PIX_W-1:0] idx;
		logic [7:0]       level;
		logic [15:0]      g_prod;
		logic [15:0]      b_prod;
		logic             last;
	} px2_t;

	// ---------------------------------------------------------------- config
	logic [STEP_W-1:0] shimmer_step_q;
	logic [7:0]        glow_level_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shimmer_step_q <= STEP_W'(RESET_STEP);
			glow_level_q   <= 8'(RESET_GLOW);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SHIMMER_STEP: shimmer_step_q <= cfg_data;
				REG_GLOW_LEVEL:   glow_level_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// --------------------------------------------------------- stall control
	logic                  en_s1;
	logic [DIV_STAGES-1:0] en_div;
	logic                  en_px1, en_px2, en_out;
	logic                  ser_take, ser_emit, ser_done;

	logic                  v_s1;
	logic [DIV_STAGES-1:0] v_div_s;
	logic                  v_px1_s1, v_px2_s2;
	logic                  busy_q;

	assign en_out = !pix_valid || pix_ready;
	assign en_px2 = !v_px2_s2 || en_out;
	assign en_px1 = !v_px1_s1 || en_px2;

	// ------------------------------------------------------------- stage 1
	s1_t s1_d, data_s1;

	assign req_ready = en_s1;
	assign en_s1     = !v_s1 || en_div[0];

	always_comb begin
		s1_d.func      = req.func;
		s1_d.step      = (shimmer_step_q == '0) ? STEP_W'(1) : shimmer_step_q;
		s1_d.glow      = glow_level_q;
		s1_d.now       = req.now_ms;
		s1_d.prod_lit  = 16'(req.energy) * 16'(PIXEL_COUNT - 1);
		s1_d.prod_base = 16'(req.energy) * 16'(BASE_SPAN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && req_valid) begin
			data_s1 <= s1_d;
		end
	end

	// ------------------------------------------------------- divider stages
	// Restoring division of now_ms by the step, DIV_BITS quotient bits per
	// stage. Only the quotient mod PIXEL_COUNT is kept: pos = 2*pos + bit,
	// folded back below PIXEL_COUNT with one subtract.
	div_t div_s   [DIV_STAGES];
	div_t div_src [DIV_STAGES];
	div_t div_nxt [DIV_STAGES];
	div_t div_in0;

	always_comb begin
		div_in0.rem  = '0;
		div_in0.num  = data_s1.now;
		div_in0.step = data_s1.step;
		div_in0.pos  = '0;
		div_in0.func = data_s1.func;
		div_in0.lit  = LIT_W'(9'(div255(data_s1.prod_lit)) + 9'd1);
		div_in0.base = 8'(BASE_MIN) + div255(data_s1.prod_base);
		div_in0.glow = data_s1.glow;
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		if (k == 0) begin : g_first
			assign div_src[k] = div_in0;
			assign en_div[k]  = !v_div_s[k] || en_div[k+1];
		end else if (k == DIV_STAGES - 1) begin : g_last
			assign div_src[k] = div_s[k-1];
			assign en_div[k]  = !v_div_s[k] || ser_take;
		end else begin : g_mid
			assign div_src[k] = div_s[k-1];
			assign en_div[k]  = !v_div_s[k] || en_div[k+1];
		end

		always_comb begin
			logic [STEP_W:0] r;
			logic [PIX_W:0]  p;
			logic            qb;
			div_nxt[k] = div_src[k];
			for (int b = 0; b < DIV_BITS; b++) begin
				r = {div_nxt[k].rem, div_nxt[k].num[NOW_W-1]};
				div_nxt[k].num = {div_nxt[k].num[NOW_W-2:0], 1'b0};
				if (r >= {1'b0, div_nxt[k].step}) begin
					div_nxt[k].rem = STEP_W'(r - {1'b0, div_nxt[k].step});
					qb = 1'b1;
				end else begin
					div_nxt[k].rem = r[STEP_W-1:0];
					qb = 1'b0;
				end
				p = {div_nxt[k].pos, qb};
				if (p >= (PIX_W+1)'(PIXEL_COUNT)) begin
					p = p - (PIX_W+1)'(PIXEL_COUNT);
				end
				div_nxt[k].pos = p[PIX_W-1:0];
			end
		end

		logic v_prev;
		if (k == 0) begin : g_v0
			assign v_prev = v_s1;
		end else begin : g_vk
			assign v_prev = v_div_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_div_s[k] <= 1'b0;
			end else if (en_div[k]) begin
				v_div_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en_div[k] && v_prev) begin
				div_s[k] <= div_nxt[k];
			end
		end
	end

	// ----------------------------------------------------- pixel serializer
	// Holds one frame and walks the pixels; takes the next frame in the same
	// cycle it hands out the last pixel of the current one.
	frame_t           frame_q;
	logic [PIX_W-1:0] cnt_q;
	logic [MOD_W-1:0] mod_q;
	px1_t             px1_d, data_px1_s1;

	assign ser_emit = busy_q && en_px1;
	assign ser_done = ser_emit && (cnt_q == PIX_W'(PIXEL_COUNT - 1));
	assign ser_take = !busy_q || ser_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			mod_q  <= '0;
		end else if (ser_take && v_div_s[DIV_STAGES-1]) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			mod_q  <= '0;
		end else if (ser_done) begin
			busy_q <= 1'b0;
		end else if (ser_emit) begin
			cnt_q <= cnt_q + PIX_W'(1);
			mod_q <= (mod_q == MOD_W'(GREEN_SPAN - 1)) ? '0 : mod_q + MOD_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ser_take && v_div_s[DIV_STAGES-1]) begin
			frame_q.func <= div_s[DIV_STAGES-1].func;
			frame_q.lit  <= div_s[DIV_STAGES-1].lit;
			frame_q.base <= div_s[DIV_STAGES-1].base;
			frame_q.glow <= div_s[DIV_STAGES-1].glow;
			frame_q.pos  <= div_s[DIV_STAGES-1].pos;
		end
	end

	// pixel intensity; off mode is simply intensity zero
	always_comb begin
		logic [PIX_W:0] i_x, p_x;
		logic           near;
		logic [8:0]     boosted;
		i_x     = {1'b0, cnt_q};
		p_x     = {1'b0, frame_q.pos};
		near    = (i_x == p_x) || (i_x == p_x + (PIX_W+1)'(1)) ||
		          (p_x == i_x + (PIX_W+1)'(1));
		boosted = 9'(frame_q.base) + (near ? 9'(SHIMMER_BOOST) : 9'd0);
		px1_d.idx  = cnt_q;
		px1_d.mod  = mod_q;
		px1_d.last = (cnt_q == PIX_W'(PIXEL_COUNT - 1));
		case (func_t'(frame_q.func))
			FUNC_LEVEL: begin
				if (LIT_W'(cnt_q) < frame_q.lit) begin
					px1_d.level = (boosted > 9'(MAX_LEVEL)) ? 8'(MAX_LEVEL) : boosted[7:0];
				end else begin
					px1_d.level = 8'(DIM_LEVEL);
				end
			end
			FUNC_GLOW: px1_d.level = frame_q.glow;
			default:   px1_d.level = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_px1_s1 <= 1'b0;
		end else if (en_px1) begin
			v_px1_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_emit) begin
			data_px1_s1 <= px1_d;
		end
	end

	// ---------------------------------------------------- color multiplies
	px2_t px2_d, data_px2_s2;

	always_comb begin
		px2_d.idx    = data_px1_s1.idx;
		px2_d.level  = data_px1_s1.level;
		px2_d.last   = data_px1_s1.last;
		px2_d.g_prod = 16'(data_px1_s1.level) *
		               (16'(GREEN_BASE) + 16'(data_px1_s1.mod));
		px2_d.b_prod = 16'(data_px1_s1.level) * 16'(BLUE_MUL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_px2_s2 <= 1'b0;
		end else if (en_px2) begin
			v_px2_s2 <= v_px1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_px2 && v_px1_s1) begin
			data_px2_s2 <= px2_d;
		end
	end

	// ------------------------------------------------------ output register
	pix_t pix_d;

	always_comb begin
		pix_d.pixel_index = 4'(data_px2_s2.idx);
		pix_d.red         = data_px2_s2.level;
		pix_d.green       = div255(data_px2_s2.g_prod);
		pix_d.blue        = div255(data_px2_s2.b_prod);
		pix_d.last_pixel  = data_px2_s2.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else if (en_out) begin
			pix_valid <= v_px2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_px2_s2) begin
			pix <= pix_d;
		end
	end

endmodule

// ----- tb/led_ring_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_ring_frame_checker
// Watches the request, pixel and register channels of the LED ring renderer,
// renders every accepted frame request into the twelve pixel items it should
// produce, and compares the pixel stream against them field by field.
// ----------------------------------------------------------------------------
module led_ring_frame_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic                            req_ready,
	input  lrlf_pkg::req_t                  req,
	input  logic                            pix_valid,
	input  logic                            pix_ready,
	input  lrlf_pkg::pix_t                  pix,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [lrlf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lrlf_pkg::STEP_W-1:0]     cfg_data,
	output int                              fail_count,
	output int                              pixels_owed
);
	import lrlf_pkg::*;

	pix_t             expected_pixels[$];
	logic [STEP_W-1:0] step_ms;
	logic [7:0]       glow;

	// warm tint of one intensity at pixel i
	function automatic pix_t warm_pixel(int unsigned lvl, int unsigned i);
		pix_t p;
		p.pixel_index = i[3:0];
		p.last_pixel  = (i == PIXEL_COUNT - 1);
		p.red         = lvl[7:0];
		p.green       = 8'((lvl * (GREEN_BASE + i % GREEN_SPAN)) / MAX_LEVEL);
		p.blue        = 8'((lvl * BLUE_MUL) / MAX_LEVEL);
		return p;
	endfunction

	function automatic pix_t render_pixel(req_t r, int unsigned i,
			logic [STEP_W-1:0] step_reg, logic [7:0] glow_reg);
		int unsigned e, now, step, lit, base, pos, gap, lvl;
		pix_t p;
		e    = r.energy;
		now  = r.now_ms;
		step = (step_reg == 0) ? 1 : step_reg; // zero step acts as one
		lit  = 1 + (e * (PIXEL_COUNT - 1)) / MAX_LEVEL;
		base = BASE_MIN + (e * BASE_SPAN) / MAX_LEVEL;
		pos  = (now / step) % PIXEL_COUNT;
		gap  = (i > pos) ? i - pos : pos - i;
		if (r.func == FUNC_LEVEL) begin
			if (i < lit) begin
				lvl = base + ((gap < 2) ? SHIMMER_BOOST : 0);
				if (lvl > MAX_LEVEL)
					lvl = MAX_LEVEL;
			end else begin
				lvl = DIM_LEVEL;
			end
			p = warm_pixel(lvl, i);
		end else if (r.func == FUNC_GLOW) begin
			p = warm_pixel(glow_reg, i);
		end else begin
			// off, and the unused selector
			p = warm_pixel(0, i);
		end
		return p;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: pixel %s expected %0d got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	initial begin
		fail_count  = 0;
		pixels_owed = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		pix_t want;
		if (!arst_n) begin
			expected_pixels.delete();
			step_ms = STEP_W'(RESET_STEP);
			glow    = 8'(RESET_GLOW);
		end else begin
			if (pix_valid && pix_ready) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected pixel item %h", $time, pix);
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					check_field("index", 8'(want.pixel_index), 8'(pix.pixel_index));
					check_field("red", want.red, pix.red);
					check_field("green", want.green, pix.green);
					check_field("blue", want.blue, pix.blue);
					check_field("last", 8'(want.last_pixel), 8'(pix.last_pixel));
				end
			end
			if (req_valid && req_ready) begin
				for (int unsigned i = 0; i < PIXEL_COUNT; i++)
					expected_pixels.push_back(render_pixel(req, i, step_ms, glow));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_SHIMMER_STEP: step_ms = cfg_data;
					REG_GLOW_LEVEL:   glow = cfg_data[7:0];
					default: ;
				endcase
			end
		end
		pixels_owed <= expected_pixels.size();
	end

endmodule

// ----- tb/led_ring_level_frame_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_ring_level_frame_tb
// Drives frame requests and register writes into the LED ring renderer with
// random gaps and output stalls; a checker beside the block predicts every
// pixel item and counts mismatches, and this top gives the verdict.
// ----------------------------------------------------------------------------
module led_ring_level_frame_tb;
	import lrlf_pkg::*;

	// selector value with no mode of its own; the block treats it as off
	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam int IDLE_PCT   = 10;
	localparam int RAND_ITEMS = 63;   // per random phase, four phases
	localparam int TAIL_WAIT  = 40;   // first pixel shows only after a request crosses the whole pipeline

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_t                  req_item = '0;
	logic                  pix_valid;
	logic                  pix_ready = 1'b0;
	pix_t                  pix_item;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [STEP_W-1:0]     cfg_data = '0;
	int                    fail_count;
	int                    pixels_owed;

	// set during one phase: neither side idles then
	bit steady = 1'b0;

	led_ring_level_frame i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req_item),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	led_ring_frame_checker i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req_item),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.pix         (pix_item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pixels_owed (pixels_owed)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Hard stop. A correct run ends long before it: 272 frames of
	// twelve pixels, with ~10% stalls on each side.
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Receiver stalls at random except in the steady phase.
	always @(posedge clk) begin
		pix_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	function automatic req_t frame_req(logic [1:0] func, logic [7:0] energy,
			logic [31:0] now);
		req_t r;
		r.func   = func;
		r.energy = energy;
		r.now_ms = now;
		return r;
	endfunction

	// Random frame. Level mode dominates; half the timestamps land on a
	// chosen shimmer position so the highlight sweeps the whole ring.
	function automatic req_t rand_frame(int unsigned step);
		int unsigned pick, s;
		logic [1:0]  func;
		logic [7:0]  energy;
		logic [31:0] now;
		s    = (step == 0) ? 1 : step;
		pick = $urandom_range(99);
		if (pick < 60)
			func = FUNC_LEVEL;
		else if (pick < 75)
			func = FUNC_GLOW;
		else if (pick < 90)
			func = FUNC_OFF;
		else
			func = FUNC_SPARE;
		pick = $urandom_range(9);
		if (pick == 0)
			energy = 8'd0;
		else if (pick == 1)
			energy = 8'd255;
		else
			energy = 8'($urandom_range(255));
		if ($urandom_range(1))
			now = $urandom();
		else
			now = s * $urandom_range(30) + $urandom_range(s - 1);
		return frame_req(func, energy, now);
	endfunction

	// Present one request and hold it until taken. req_ready is sampled at
	// the falling edge: inputs only move at rising edges, so that is the
	// value seen by the next rising edge.
	task automatic send_frame(req_t r);
		bit taken;
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req_item  <= r;
		do begin
			@(negedge clk);
			taken = req_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Drop valid and wait until every owed pixel has come out.
	task automatic drain();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (pixels_owed != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [STEP_W-1:0] data);
		bit taken;
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [STEP_W-1:0] step;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: step 90 ms, glow 18.
		send_frame(frame_req(FUNC_LEVEL, 8'd0, 32'd0));              // shortest bar
		send_frame(frame_req(FUNC_LEVEL, 8'd255, 32'd0));            // full bar, shimmer at 0
		send_frame(frame_req(FUNC_LEVEL, 8'd255, 32'd990));          // shimmer at last pixel
		send_frame(frame_req(FUNC_LEVEL, 8'd255, 32'hFFFF_FFFF));
		send_frame(frame_req(FUNC_LEVEL, 8'd127, 32'd585));
		send_frame(frame_req(FUNC_LEVEL, 8'd23, 32'd90));            // lit 1, boost from pixel 1
		send_frame(frame_req(FUNC_LEVEL, 8'd24, 32'd270));           // lit steps to 2
		send_frame(frame_req(FUNC_OFF, 8'd255, 32'h1234_5678));
		send_frame(frame_req(FUNC_GLOW, 8'd0, 32'd0));
		send_frame(frame_req(FUNC_SPARE, 8'hAA, 32'h5555_5555));
		send_frame(frame_req(FUNC_LEVEL, 8'h55, 32'hAAAA_AAAA));
		send_frame(frame_req(FUNC_GLOW, 8'd255, 32'hFFFF_FFFF));
		drain();

		// Zero step counts as one; glow takes only the low byte of the data.
		write_reg(REG_SHIMMER_STEP, 16'h0000);
		write_reg(REG_GLOW_LEVEL, 16'hABFF);
		send_frame(frame_req(FUNC_LEVEL, 8'd255, 32'd5));
		send_frame(frame_req(FUNC_LEVEL, 8'd200, 32'hFFFF_FFFF));
		send_frame(frame_req(FUNC_GLOW, 8'd0, 32'd0));
		send_frame(frame_req(FUNC_LEVEL, 8'd100, 32'd11));
		drain();

		// Slowest shimmer, glow fully dark.
		write_reg(REG_SHIMMER_STEP, 16'hFFFF);
		write_reg(REG_GLOW_LEVEL, 16'h5500);
		send_frame(frame_req(FUNC_LEVEL, 8'd255, 32'hFFFF_FFFF));
		send_frame(frame_req(FUNC_GLOW, 8'd77, 32'd12345));
		send_frame(frame_req(FUNC_LEVEL, 8'd180, 32'd458745));
		send_frame(frame_req(FUNC_SPARE, 8'd255, 32'hFFFF_FFFF));
		drain();

		// Random phases, each under its own register setting. The third one
		// runs with no idling on either side.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       step = STEP_W'($urandom_range(1, 8));
				1:       step = STEP_W'($urandom_range(65535));
				2:       step = STEP_W'($urandom_range(20, 200));
				default: step = STEP_W'($urandom_range(1, 3000));
			endcase
			write_reg(REG_SHIMMER_STEP, step);
			write_reg(REG_GLOW_LEVEL, STEP_W'($urandom_range(65535)));
			steady = (ph == 2);
			for (int n = 0; n < RAND_ITEMS; n++)
				send_frame(rand_frame(step));
			drain();
		end
		steady = 1'b0;

		repeat (TAIL_WAIT) @(posedge clk);
		if (fail_count == 0 && pixels_owed == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- led_ring_level_frame.f -----
rtl/lrlf_pkg.sv
rtl/led_ring_level_frame.sv
tb/led_ring_frame_checker.sv
tb/led_ring_level_frame_tb.sv
